// ----- rtl/integer_literal_parser_core_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef INTEGER_LITERAL_PARSER_CORE_MACROS_SVH
`define INTEGER_LITERAL_PARSER_CORE_MACROS_SVH

// property checked only while out of reset
`define ILP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("integer literal parser check failed");

// property checked on every edge, reset included
`define ILP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("integer literal parser check failed");

`endif

// ----- rtl/ilp_pkg.sv -----
// types, character codes and helpers for the integer literal parser
// no dependencies
`timescale 1ns / 1ps

package ilp_pkg;

    localparam int MAG_W = 64;
    localparam int ACC_W = MAG_W + 4;
    localparam int DIG_W = 5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [DIG_W-1:0] DIGIT_NONE = 5'h1f;

    // largest positive magnitude and largest negative magnitude
    localparam logic [MAG_W-1:0] LIMIT_POS = 64'h7fff_ffff_ffff_ffff;
    localparam logic [MAG_W-1:0] LIMIT_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_ZERO  = 2'd1,
        PH_BODY  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        RAD_DEC = 2'd0,
        RAD_BIN = 2'd1,
        RAD_OCT = 2'd2,
        RAD_HEX = 2'd3
    } t_radix;

    typedef struct packed {
        t_phase           phase;
        t_radix           radix;
        logic [MAG_W-1:0] magnitude;
        logic             is_negative;
        logic             overflowed;
        logic             stopped;
        logic             keep_next;
        logic             sign_allowed;
    } t_state;

    localparam t_state STATE_INIT = '{
        phase:        PH_FIRST,
        radix:        RAD_DEC,
        magnitude:    '0,
        is_negative:  1'b0,
        overflowed:   1'b0,
        stopped:      1'b0,
        keep_next:    1'b0,
        sign_allowed: 1'b1
    };

    function automatic logic [DIG_W-1:0] digit_of(input logic [7:0] ch);
        logic [7:0] d;
        begin
            d = 8'hff;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                d = ch - CH_ZERO;
            end else if (ch >= CH_LA && ch <= CH_LF) begin
                d = ch - CH_LA + 8'd10;
            end else if (ch >= CH_UA && ch <= CH_UF) begin
                d = ch - CH_UA + 8'd10;
            end
            digit_of = (d == 8'hff) ? DIGIT_NONE : d[DIG_W-1:0];
        end
    endfunction

    function automatic logic [DIG_W-1:0] radix_value(input t_radix r);
        logic [DIG_W-1:0] v;
        begin
            unique case (r)
                RAD_BIN: v = 5'd2;
                RAD_OCT: v = 5'd8;
                RAD_HEX: v = 5'd16;
                default: v = 5'd10;
            endcase
            radix_value = v;
        end
    endfunction

endpackage

// ----- rtl/ilp_accum.sv -----
// multiply-by-radix, digit add and range check for one digit
// depends on ilp_pkg
`timescale 1ns / 1ps

module ilp_accum import ilp_pkg::*; (
    input  logic [MAG_W-1:0] i_magnitude,
    input  t_radix           i_radix,
    input  logic [DIG_W-1:0] i_digit,
    input  logic             i_is_negative,
    output logic [MAG_W-1:0] o_magnitude,
    output logic             o_over
);

    logic [ACC_W-1:0] w_mag;
    logic [ACC_W-1:0] w_prod;
    logic [ACC_W-1:0] w_sum;
    logic [ACC_W-1:0] w_limit;

    assign w_mag = {{(ACC_W-MAG_W){1'b0}}, i_magnitude};

    // radix is a constant per token: shifts and one add
    always_comb begin
        unique case (i_radix)
            RAD_BIN: w_prod = w_mag << 1;
            RAD_OCT: w_prod = w_mag << 3;
            RAD_HEX: w_prod = w_mag << 4;
            default: w_prod = (w_mag << 3) + (w_mag << 1);
        endcase
    end

    assign w_sum   = w_prod + {{(ACC_W-DIG_W){1'b0}}, i_digit};
    assign w_limit = {{(ACC_W-MAG_W){1'b0}}, (i_is_negative ? LIMIT_NEG : LIMIT_POS)};

    // m*r + d above the limit is the same test as m > (limit - d) / r
    assign o_over      = (w_sum > w_limit);
    assign o_magnitude = w_sum[MAG_W-1:0];

endmodule

// ----- rtl/ilp_step.sv -----
// next-state logic for one character: prefix, underscore, sign, digit
// depends on ilp_pkg and ilp_accum
`timescale 1ns / 1ps

module ilp_step import ilp_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_char,
    output t_state     o_state
);

    logic [DIG_W-1:0] w_digit;
    logic [MAG_W-1:0] w_mag_next;
    logic             w_over;
    logic             w_body;
    logic             w_is_prefix;

    assign w_digit     = digit_of(i_char);
    assign w_is_prefix = (i_char == CH_B) || (i_char == CH_O) || (i_char == CH_X);

    ilp_accum u_accum (
        .i_magnitude   (i_state.magnitude),
        .i_radix       (i_state.radix),
        .i_digit       (w_digit),
        .i_is_negative (i_state.is_negative),
        .o_magnitude   (w_mag_next),
        .o_over        (w_over)
    );

    always_comb begin
        o_state = i_state;
        w_body  = 1'b0;

        unique case (i_state.phase)
            PH_FIRST: begin
                w_body        = 1'b1;
                o_state.phase = (i_char == CH_ZERO) ? PH_ZERO : PH_BODY;
            end
            PH_ZERO: begin
                o_state.phase = PH_BODY;
                if (w_is_prefix) begin
                    unique case (i_char)
                        CH_B:    o_state.radix = RAD_BIN;
                        CH_O:    o_state.radix = RAD_OCT;
                        default: o_state.radix = RAD_HEX;
                    endcase
                    o_state.magnitude    = '0;
                    o_state.sign_allowed = 1'b1;
                end else begin
                    w_body = 1'b1;
                end
            end
            default: begin
                w_body = 1'b1;
            end
        endcase

        if (w_body) begin
            // an underscore is dropped, the character after it kept as is
            if (!i_state.keep_next && i_char == CH_UNDER) begin
                o_state.keep_next = 1'b1;
            end else begin
                o_state.keep_next = 1'b0;
                if (!i_state.stopped) begin
                    if (i_state.sign_allowed && (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                        o_state.is_negative  = (i_char == CH_MINUS);
                        o_state.sign_allowed = 1'b0;
                    end else begin
                        o_state.sign_allowed = 1'b0;
                        if (w_digit >= radix_value(i_state.radix)) begin
                            o_state.stopped = 1'b1;
                        end else if (!i_state.overflowed) begin
                            if (w_over) begin
                                o_state.overflowed = 1'b1;
                            end else begin
                                o_state.magnitude = w_mag_next;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/integer_literal_parser_core.sv -----
// integer literal parser top level: input register, step logic, result register
// depends on ilp_pkg and ilp_step
`timescale 1ns / 1ps

// channel | dir | tdata                | tuser              | tlast
// s_axis  | in  | [7:0] character      | -                  | last_char
// m_axis  | out | [63:0] value         | [0] overflow_error | -
//
// one character per cycle, except that a final character stalls while a result waits; a
// token's result is registered through the input register and then the result register,
// around the combinational shift-add and limit compare
// synchronous active-low reset returns the token state to the start of a literal
// a waiting result stalls only a final character; others keep flowing

module integer_literal_parser_core import ilp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] character
    input  logic        i_s_axis_tlast,   // last_char
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] value
    output logic [0:0]  o_m_axis_tuser    // [0] overflow_error
);

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;
    t_state      r_state;
    t_state      w_step;
    logic        r_out_valid;
    logic [63:0] r_value;
    logic        r_ovf;
    logic        w_advance;
    logic        w_in_xfer;
    logic        w_out_xfer;
    logic [63:0] n_value;

    assign w_out_xfer = r_out_valid && i_m_axis_tready;
    assign w_advance  = r_in_valid && (!r_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;

    ilp_step u_step (
        .i_state (r_state),
        .i_char  (r_char),
        .o_state (w_step)
    );

    assign n_value = w_step.overflowed ? '0 :
                     (w_step.is_negative ? (64'd0 - w_step.magnitude) : w_step.magnitude);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_state <= r_last ? STATE_INIT : w_step;
            end

            if (w_advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_char <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
        if (w_advance && r_last) begin
            r_value <= n_value;
            r_ovf   <= w_step.overflowed;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_value;
    assign o_m_axis_tuser[0] = r_ovf;

endmodule

// ----- rtl/ilp_checker.sv -----
// port-level checks on the integer literal parser, bound to the top level
// depends on integer_literal_parser_core_macros.svh
`timescale 1ns / 1ps
`include "integer_literal_parser_core_macros.svh"

module ilp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // a result waiting on the output holds until its transfer
    `ILP_ASSERT(a_out_held, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)

    // an overflowed literal always reads as zero
    `ILP_ASSERT(a_ovf_zero, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 64'd0))

    // with the output empty the input side never stalls
    `ILP_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)

    // reset leaves no result pending
    `ILP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind integer_literal_parser_core ilp_checker u_ilp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- tb/tb_top.sv -----
// self-checking bench for integer_literal_parser_core: literal tokens in, values out
// depends on ilp_pkg and the core; the scoreboard class tracks the token state itself
`timescale 1ns / 1ps

module tb_top;
    import ilp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_CHARS   = 300;

    typedef logic [7:0] t_chars[$];

    logic        i_clk;
    logic        rst_n;
    logic        s_valid;
    logic [7:0]  s_data;
    logic        s_last;
    logic        m_ready;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [63:0]  o_m_axis_tdata;
    wire [0:0]   o_m_axis_tuser;

    int          n_chars;
    int          n_tokens;
    int          n_results;
    int          idle_cycles;
    bit          no_idle;
    bit          hold_done;

    // expected value of each token, worked out one character at a time
    class literal_scoreboard;
        t_phase           phase;
        t_radix           radix;
        logic [63:0]      magnitude;
        bit               negative;
        bit               overflowed;
        bit               stopped;
        bit               keep_next;
        bit               sign_ok;
        logic [64:0]      expected_q[$];   // {overflow_error, value}
        int               mismatches;
        int               n_overflow;

        function new();
            clear();
        endfunction

        function void clear();
            phase      = PH_FIRST;
            radix      = RAD_DEC;
            magnitude  = '0;
            negative   = 1'b0;
            overflowed = 1'b0;
            stopped    = 1'b0;
            keep_next  = 1'b0;
            sign_ok    = 1'b1;
        endfunction

        function void accumulate(logic [7:0] ch);
            logic [63:0] base;
            logic [63:0] d;
            logic [63:0] limit;
            if (stopped) return;
            if (sign_ok && (ch == CH_PLUS || ch == CH_MINUS)) begin
                negative = (ch == CH_MINUS);
                sign_ok  = 1'b0;
                return;
            end
            sign_ok = 1'b0;
            case (radix)
                RAD_BIN: base = 64'd2;
                RAD_OCT: base = 64'd8;
                RAD_HEX: base = 64'd16;
                default: base = 64'd10;
            endcase
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                d = ch - CH_ZERO;
            end else if (ch >= CH_LA && ch <= CH_LF) begin
                d = ch - CH_LA + 64'd10;
            end else if (ch >= CH_UA && ch <= CH_UF) begin
                d = ch - CH_UA + 64'd10;
            end else begin
                d = 64'd255;
            end
            if (d >= base) begin
                stopped = 1'b1;
                return;
            end
            if (overflowed) return;
            limit = negative ? LIMIT_NEG : LIMIT_POS;
            if (magnitude > (limit - d) / base) begin
                overflowed = 1'b1;
                return;
            end
            magnitude = magnitude * base + d;
        endfunction

        // an underscore is dropped and the character after it passes as it is
        function void body_char(logic [7:0] ch);
            if (!keep_next && ch == CH_UNDER) begin
                keep_next = 1'b1;
                return;
            end
            keep_next = 1'b0;
            accumulate(ch);
        endfunction

        function void note_char(logic [7:0] ch, logic is_last);
            if (phase == PH_FIRST) begin
                body_char(ch);
                phase = (ch == CH_ZERO) ? PH_ZERO : PH_BODY;
            end else if (phase == PH_ZERO) begin
                phase = PH_BODY;
                if (ch == CH_B || ch == CH_O || ch == CH_X) begin
                    radix     = (ch == CH_B) ? RAD_BIN : (ch == CH_O) ? RAD_OCT : RAD_HEX;
                    magnitude = '0;
                    sign_ok   = 1'b1;
                end else begin
                    body_char(ch);
                end
            end else begin
                body_char(ch);
            end
            if (is_last) begin
                if (overflowed) begin
                    expected_q.push_back({1'b1, 64'd0});
                    n_overflow++;
                end else begin
                    expected_q.push_back({1'b0, negative ? 64'd0 - magnitude : magnitude});
                end
                clear();
            end
        endfunction

        function void check_result(logic [63:0] value, logic ovf);
            logic [64:0] exp_r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: value=%h overflow=%b", value, ovf);
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r[63:0] !== value || exp_r[64] !== ovf) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: value exp %h got %h, overflow exp %b got %b",
                             exp_r[63:0], value, exp_r[64], ovf);
            end
        endfunction
    endclass

    literal_scoreboard sb = new();

    integer_literal_parser_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),     // [7:0] character
        .i_s_axis_tlast  (s_last),     // last_char
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [63:0] value
        .o_m_axis_tuser  (o_m_axis_tuser)    // [0] overflow_error
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_chars to_chars(input string s);
        t_chars q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic t_chars random_literal();
        t_chars      q;
        string       digits;
        logic [63:0] v;
        logic [7:0]  c;
        int          sel;
        int          pick;
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        sel = $urandom_range(0, 3);
        case (sel)
            1: q = to_chars("0b");
            2: q = to_chars("0o");
            3: q = to_chars("0x");
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) q.push_back($urandom_range(0, 1) ? "-" : "+");
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            v = $urandom_range(0, 999);
        end else if (pick < 7) begin
            v = {$urandom, $urandom};
        end else if (pick == 7) begin
            // just around the positive and negative limits
            v = LIMIT_POS - 64'd1 + $urandom_range(0, 3);
        end else if (pick == 8) begin
            v = {$urandom, $urandom} >> $urandom_range(0, 60);
        end else begin
            v = {1'b1, 31'($urandom), $urandom};
        end
        case (sel)
            1: digits = $sformatf("%0b", v);
            2: digits = $sformatf("%0o", v);
            3: digits = $sformatf("%0h", v);
            default: digits = $sformatf("%0d", v);
        endcase
        for (int i = 0; i < digits.len(); i++) begin
            c = digits[i];
            if (sel == 3 && c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'h20;
            if ($urandom_range(0, 9) == 0) begin
                q.push_back("_");
                if ($urandom_range(0, 5) == 0) q.push_back("_");
            end
            q.push_back(c);
        end
        if ($urandom_range(0, 9) == 0) q.push_back("1");
        if ($urandom_range(0, 9) == 0)
            q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 15) == 0) q.push_back("_");
        return q;
    endfunction

    // entered and left at a falling edge
    task automatic send_char(input logic [7:0] ch, input logic is_last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = ch;
        s_last  = is_last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_char(ch, is_last);
        n_chars++;
        @(negedge i_clk);
    endtask

    task automatic send_token(input t_chars tok);
        for (int i = 0; i < tok.size(); i++) send_char(tok[i], i == tok.size() - 1);
        n_tokens++;
    endtask

    // receiver side: random stalls plus one long hold-off while characters keep coming
    initial begin
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_results >= 20) begin
                hold_done = 1'b1;
                m_ready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall > 0) begin
                stall--;
                m_ready = 1'b0;
            end else begin
                stall   = gap_len();
                m_ready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
            n_results++;
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        string  directed[];
        t_chars tok;
        int     random_start;
        s_valid     = 1'b0;
        s_data      = 8'h00;
        s_last      = 1'b0;
        rst_n       = 1'b0;
        no_idle     = 1'b0;
        hold_done   = 1'b0;
        n_chars     = 0;
        n_tokens    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        directed = '{"0", "7", "9223372036854775807", "-9223372036854775808",
                     "9223372036854775808", "-9223372036854775809", "0x7FFFffffFFFFffff",
                     "-0x8000000000000000", "0b1011", "0o777", "+42", "-0", "1_000", "1__2",
                     "12_", "-", "0x", "12 3", "0x0x5", "-0x5", "0_x5", "0b12",
                     "99999999999999999999999", "+-5", "0xaBcDeF"};
        foreach (directed[i]) send_token(to_chars(directed[i]));
        // character code zero straight after an underscore
        tok = to_chars("5_");
        tok.push_back(8'h00);
        tok.push_back("7");
        send_token(tok);
        tok = '{8'hff, 8'h80};
        send_token(tok);

        random_start = n_chars;
        while (n_chars - random_start < RANDOM_CHARS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            send_token(random_literal());
        end
        no_idle = 1'b0;
        s_valid = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d tokens in %0d characters, %0d results checked (%0d overflowed)",
                 n_tokens, n_chars, n_results, sb.n_overflow);
        $display("bases 2/8/10/16 with signs, underscores, limits, stray bytes, one long stall");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ilp_pkg.sv
rtl/ilp_accum.sv
rtl/ilp_step.sv
rtl/integer_literal_parser_core.sv
rtl/ilp_checker.sv
tb/tb_top.sv
